// ----- src/nav_key_debounce_autorepeat_unit_defines.svh -----
// Assertion macros shared by the navigation key debounce checker.
`ifndef NAV_KEY_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH
`define NAV_KEY_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NKDA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("nkda: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define NKDA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("nkda: next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define NKDA_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("nkda: reset check failed");

`endif

// ----- src/nkda_pkg.sv -----
// Types, register indexes and reset values for the navigation key debounce unit.
package nkda_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS        = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INITIAL_MS  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL_MS = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTICAL_STEPS     = 8'd3;

   localparam logic [15:0] DEBOUNCE_RESET        = 16'd130;
   localparam logic [15:0] REPEAT_INITIAL_RESET  = 16'd700;
   localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd95;
   localparam logic [1:0]  VERTICAL_STEPS_RESET  = 2'd2;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   typedef struct packed {
      logic        edge_left;
      logic        edge_right;
      logic        edge_up;
      logic        edge_down;
      logic        held_left;
      logic        held_right;
      logic        held_up;
      logic        held_down;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] move_dir;
      logic [1:0] move_count;
      logic       handled;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] repeat_initial_ms;
      logic [15:0] repeat_interval_ms;
      logic [1:0]  vertical_repeat_steps;
   } cfg_type;

endpackage

// ----- src/nkda_csr.sv -----
// Configuration register file for the navigation key debounce unit.
module nkda_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [nkda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nkda_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output nkda_pkg::cfg_type               cfg
);
   import nkda_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes to unknown indexes leave every register unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:        cfg_in.debounce_ms           = csr_wdata;
            CSR_REPEAT_INITIAL_MS:  cfg_in.repeat_initial_ms     = csr_wdata;
            CSR_REPEAT_INTERVAL_MS: cfg_in.repeat_interval_ms    = csr_wdata;
            CSR_VERTICAL_STEPS:     cfg_in.vertical_repeat_steps = csr_wdata[1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms           <= DEBOUNCE_RESET;
         cfg_ff.repeat_initial_ms     <= REPEAT_INITIAL_RESET;
         cfg_ff.repeat_interval_ms    <= REPEAT_INTERVAL_RESET;
         cfg_ff.vertical_repeat_steps <= VERTICAL_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/nav_key_debounce_autorepeat_unit.sv -----
// Top level of the navigation key debounce and auto-repeat unit.
// A sample accepted into the input register moves on to the result register that drives rsp_valid.
// Throughput: one sample per cycle without rsp_stall; an input and a result register bracket it.
// The decision and the state update are one short compare stage, so back-to-back samples flow.
// Reset is synchronous and active high: it restores the register defaults,
// forgets the last edge, disarms repeat and empties both pipeline registers.
module nav_key_debounce_autorepeat_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  nkda_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output nkda_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nkda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nkda_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nkda_pkg::*;

   cfg_type cfg;

   // The register file takes a write in every cycle; the user must change configuration only
   // while the unit is idle (the unit does not enforce this), so no transaction can see a half update.
   assign csr_ready = 1'b1;

   nkda_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline registers: the sampled input and the finished result.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff,  s1_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;

   // Navigation state carried from one sample to the next.
   logic        last_valid_ff, last_valid_in;
   dir_type     last_dir_ff,   last_dir_in;
   logic [31:0] last_time_ff,  last_time_in;
   logic        armed_ff,      armed_in;
   dir_type     rep_dir_ff,    rep_dir_in;
   logic [31:0] due_ff,        due_in;

   logic s1_advance;
   logic req_accept;

   // The sample in the input register moves on when the result register is
   // empty or its transaction completes this cycle.
   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   // Decision logic for the sample held in the input register.
   logic [3:0]  edge_vec;
   logic [3:0]  held_vec;
   logic        any_edge;
   dir_type     edge_dir;
   logic [31:0] since_last;
   logic        bounce;
   logic [1:0]  vert_steps;
   rsp_type     result;

   assign edge_vec = {s1_data_ff.edge_down, s1_data_ff.edge_up,
                      s1_data_ff.edge_right, s1_data_ff.edge_left};
   assign held_vec = {s1_data_ff.held_down, s1_data_ff.held_up,
                      s1_data_ff.held_right, s1_data_ff.held_left};
   assign any_edge = |edge_vec;

   // Left wins over right, right over up, up over down.
   always_comb begin
      if (edge_vec[0]) begin
         edge_dir = DIR_LEFT;
      end else if (edge_vec[1]) begin
         edge_dir = DIR_RIGHT;
      end else if (edge_vec[2]) begin
         edge_dir = DIR_UP;
      end else begin
         edge_dir = DIR_DOWN;
      end
   end

   // The bounce window is measured with wrapping subtraction.
   assign since_last = s1_data_ff.now_ms - last_time_ff;
   assign bounce     = last_valid_ff && (last_dir_ff == edge_dir) &&
                       (since_last < {16'd0, cfg.debounce_ms});

   // A vertical step count of zero behaves as one.
   assign vert_steps = (cfg.vertical_repeat_steps == 2'd0) ? 2'd1
                                                           : cfg.vertical_repeat_steps;

   always_comb begin
      last_valid_in = last_valid_ff;
      last_dir_in   = last_dir_ff;
      last_time_in  = last_time_ff;
      armed_in      = armed_ff;
      rep_dir_in    = rep_dir_ff;
      due_in        = due_ff;
      result        = '0;

      if (any_edge) begin
         if (bounce) begin
            // A bounce is swallowed: handled, no move, state untouched.
            result.handled = 1'b1;
         end else begin
            last_valid_in     = 1'b1;
            last_dir_in       = edge_dir;
            last_time_in      = s1_data_ff.now_ms;
            armed_in          = 1'b1;
            rep_dir_in        = edge_dir;
            due_in            = s1_data_ff.now_ms + {16'd0, cfg.repeat_initial_ms};
            result.move_dir   = edge_dir;
            result.move_count = 2'd1;
            result.handled    = 1'b1;
         end
      end else if (held_vec == 4'd0) begin
         // Every key released: repeat stops.
         armed_in = 1'b0;
      end else if (armed_ff && !(s1_data_ff.now_ms < due_ff)) begin
         // The due-time test is a plain unsigned compare with no wrap handling.
         if (!held_vec[rep_dir_ff]) begin
            // Only other keys are held when the repeat falls due.
            armed_in = 1'b0;
         end else begin
            due_in            = s1_data_ff.now_ms + {16'd0, cfg.repeat_interval_ms};
            result.move_dir   = rep_dir_ff;
            result.move_count = rep_dir_ff[1] ? vert_steps : 2'd1;
            result.handled    = 1'b1;
         end
      end
   end

   // Next values of the pipeline registers.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (s1_advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         last_dir_ff   <= DIR_LEFT;
         last_time_ff  <= '0;
         armed_ff      <= 1'b0;
         rep_dir_ff    <= DIR_LEFT;
         due_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // State moves only when the sample's result is committed.
         if (s1_advance) begin
            last_valid_ff <= last_valid_in;
            last_dir_ff   <= last_dir_in;
            last_time_ff  <= last_time_in;
            armed_ff      <= armed_in;
            rep_dir_ff    <= rep_dir_in;
            due_ff        <= due_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- src/nkda_checker.sv -----
// Port-level assertion checker for the navigation key debounce unit, with its bind.
`include "nav_key_debounce_autorepeat_unit_defines.svh"

module nkda_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input nkda_pkg::rsp_type rsp_data
);
   import nkda_pkg::*;

   `NKDA_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)

   `NKDA_ASSERT_NEXT(a_stalled_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

   `NKDA_ASSERT_IMPLY(a_no_move_dir_zero, clock, reset,
      rsp_valid && (rsp_data.move_count == 2'd0), rsp_data.move_dir == 2'd0)

   `NKDA_ASSERT_IMPLY(a_move_is_handled, clock, reset,
      rsp_valid && (rsp_data.move_count != 2'd0), rsp_data.handled)

endmodule

bind nav_key_debounce_autorepeat_unit nkda_checker u_nkda_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the navigation key debounce and auto-repeat unit.
module testbench;
   import nkda_pkg::*;

   localparam int unsigned HALF_PERIOD     = 5;
   localparam int unsigned RESET_CYCLES    = 7;
   localparam int unsigned ITEMS_PER_PHASE = 90;
   localparam int unsigned PHASE_COUNT     = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned SETTLE_CYCLES   = 4;

   localparam logic [3:0] KEY_LEFT  = 4'b0001 << DIR_LEFT;
   localparam logic [3:0] KEY_RIGHT = 4'b0001 << DIR_RIGHT;
   localparam logic [3:0] KEY_UP    = 4'b0001 << DIR_UP;
   localparam logic [3:0] KEY_DOWN  = 4'b0001 << DIR_DOWN;
   localparam logic [3:0] ALL_KEYS  = 4'b1111;
   localparam logic [3:0] NO_KEYS   = 4'b0000;

   // Shadow of the unit: it keeps its own copy of the registers and of the
   // edge and repeat state, and queues the move that each sample should cause.
   class nav_move_tracker;
      rsp_type     expected_moves[$];
      int unsigned failures;
      int unsigned edge_moves;
      int unsigned repeat_moves;
      int unsigned bounces;
      int unsigned disarms;

      logic [15:0] debounce_ms;
      logic [15:0] repeat_initial_ms;
      logic [15:0] repeat_interval_ms;
      logic [1:0]  vertical_steps;

      logic        last_edge_known;
      dir_type     last_edge_dir;
      logic [31:0] last_edge_time;
      logic        repeat_armed;
      dir_type     repeat_dir;
      logic [31:0] repeat_due;

      function new();
         debounce_ms        = DEBOUNCE_RESET;
         repeat_initial_ms  = REPEAT_INITIAL_RESET;
         repeat_interval_ms = REPEAT_INTERVAL_RESET;
         vertical_steps     = VERTICAL_STEPS_RESET;
         last_edge_known    = 1'b0;
         last_edge_dir      = DIR_LEFT;
         last_edge_time     = '0;
         repeat_armed       = 1'b0;
         repeat_dir         = DIR_LEFT;
         repeat_due         = '0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] reg_value);
         case (reg_index)
            CSR_DEBOUNCE_MS:        debounce_ms = reg_value;
            CSR_REPEAT_INITIAL_MS:  repeat_initial_ms = reg_value;
            CSR_REPEAT_INTERVAL_MS: repeat_interval_ms = reg_value;
            CSR_VERTICAL_STEPS:     vertical_steps = reg_value[1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(input req_type s);
         logic [3:0]  edges;
         logic [3:0]  held;
         logic [31:0] since_edge;
         dir_type     d;
         rsp_type     move;
         edges = {s.edge_down, s.edge_up, s.edge_right, s.edge_left};
         held  = {s.held_down, s.held_up, s.held_right, s.held_left};
         move  = '0;
         if (edges != 4'b0000) begin
            if (edges[DIR_LEFT]) d = DIR_LEFT;
            else if (edges[DIR_RIGHT]) d = DIR_RIGHT;
            else if (edges[DIR_UP]) d = DIR_UP;
            else d = DIR_DOWN;
            since_edge = s.now_ms - last_edge_time;
            if (last_edge_known && last_edge_dir == d && since_edge < {16'd0, debounce_ms}) begin
               // A bounce is swallowed without touching any state.
               move.handled = 1'b1;
               bounces++;
            end else begin
               last_edge_known = 1'b1;
               last_edge_dir   = d;
               last_edge_time  = s.now_ms;
               repeat_armed    = 1'b1;
               repeat_dir      = d;
               repeat_due      = s.now_ms + {16'd0, repeat_initial_ms};
               move.move_dir   = d;
               move.move_count = 2'd1;
               move.handled    = 1'b1;
               edge_moves++;
            end
         end else if (held == NO_KEYS) begin
            repeat_armed = 1'b0;
         end else if (repeat_armed && s.now_ms >= repeat_due) begin
            if (!held[repeat_dir]) begin
               repeat_armed = 1'b0;
               disarms++;
            end else begin
               move.move_dir = repeat_dir;
               if (repeat_dir == DIR_LEFT || repeat_dir == DIR_RIGHT) move.move_count = 2'd1;
               else if (vertical_steps == 2'd0) move.move_count = 2'd1;
               else move.move_count = vertical_steps;
               move.handled = 1'b1;
               repeat_due   = s.now_ms + {16'd0, repeat_interval_ms};
               repeat_moves++;
            end
         end
         expected_moves = {expected_moves, move};
      endfunction

      function void check_move(input rsp_type got);
         rsp_type want;
         if (expected_moves.size() == 0) begin
            $error("unexpected move transaction: dir %0d count %0d handled %0d",
                   got.move_dir, got.move_count, got.handled);
            failures++;
            return;
         end
         want = expected_moves.pop_front();
         if (got.move_dir !== want.move_dir) begin
            $error("move_dir: expected %0d, actual %0d", want.move_dir, got.move_dir);
            failures++;
         end
         if (got.move_count !== want.move_count) begin
            $error("move_count: expected %0d, actual %0d", want.move_count, got.move_count);
            failures++;
         end
         if (got.handled !== want.handled) begin
            $error("handled: expected %0d, actual %0d", want.handled, got.handled);
            failures++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   nav_move_tracker tracker = new();

   // Stimulus state: the millisecond clock that the key samples carry and
   // the register settings currently loaded into the unit.
   logic [31:0] sample_ms;
   cfg_type     active_cfg;
   bit          gaps_on;
   bit          hold_off_request;
   int unsigned items_sent;
   int unsigned settings_applied;

   nav_key_debounce_autorepeat_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Time between samples, spread over the debounce window, the repeat
   // interval and the initial delay, with rare large jumps.
   function automatic logic [31:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 45) return $urandom_range(0, active_cfg.repeat_interval_ms + 2);
      if (r < 70) return $urandom_range(0, active_cfg.debounce_ms + 2);
      if (r < 95) return $urandom_range(active_cfg.repeat_initial_ms / 2,
                                        active_cfg.repeat_initial_ms + 2);
      if (r < 98) return $urandom_range(0, 32'h0001_FFFF);
      return $urandom;
   endfunction

   // While a key is held the clock moves in steps that reach the first
   // repeat within a handful of samples and then keep repeats coming.
   function automatic logic [31:0] hold_step();
      if ($urandom_range(0, 9) < 6) return $urandom_range(0, active_cfg.repeat_interval_ms + 2);
      return $urandom_range(0, active_cfg.repeat_initial_ms / 3 + 2);
   endfunction

   function automatic req_type pack_sample(input logic [3:0] edges, input logic [3:0] held);
      req_type s;
      s.edge_left  = edges[DIR_LEFT];
      s.edge_right = edges[DIR_RIGHT];
      s.edge_up    = edges[DIR_UP];
      s.edge_down  = edges[DIR_DOWN];
      s.held_left  = held[DIR_LEFT];
      s.held_right = held[DIR_RIGHT];
      s.held_up    = held[DIR_UP];
      s.held_down  = held[DIR_DOWN];
      s.now_ms     = sample_ms;
      return s;
   endfunction

   // Offers one sample and holds it until the unit takes it. Valid stays high
   // into the next call unless an idle gap is taken here.
   task automatic send_sample(input req_type s);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      tracker.note_sample(s);
      items_sent++;
      if (gaps_on && $urandom_range(0, 1) == 1) begin
         req_valid <= 1'b0;
         repeat (idle_cycles()) @(posedge clock);
      end
   endtask

   task automatic sample_at(input logic [31:0] t, input logic [3:0] edges,
                            input logic [3:0] held);
      sample_ms = t;
      send_sample(pack_sample(edges, held));
   endtask

   // Stops offering samples until every predicted move has come back, then
   // lets the pipeline settle.
   task automatic drain_moves();
      req_valid <= 1'b0;
      while (tracker.expected_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] reg_value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(reg_index, reg_value);
   endtask

   // Loads a full register setting. The step count goes out with random
   // upper bits, and sometimes a write to an unused index follows.
   task automatic apply_settings(input cfg_type c);
      csr_write(CSR_DEBOUNCE_MS, c.debounce_ms);
      csr_write(CSR_REPEAT_INITIAL_MS, c.repeat_initial_ms);
      csr_write(CSR_REPEAT_INTERVAL_MS, c.repeat_interval_ms);
      csr_write(CSR_VERTICAL_STEPS, {14'($urandom_range(0, 16383)), c.vertical_repeat_steps});
      if ($urandom_range(0, 1) == 1)
         csr_write(CSR_INDEX_W'($urandom_range(CSR_VERTICAL_STEPS + 1, (1 << CSR_INDEX_W) - 1)),
                   CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      active_cfg = c;
      settings_applied++;
      @(posedge clock);
   endtask

   // One press of a key: the edge, perhaps a contact bounce, a run of held
   // samples that should trigger repeats, and perhaps a full release.
   task automatic keystroke();
      dir_type     key;
      logic [3:0]  one_hot;
      logic [3:0]  extra;
      int unsigned holds;
      key     = dir_type'($urandom_range(0, 3));
      one_hot = 4'b0001 << key;
      extra   = ($urandom_range(0, 4) == 0) ? 4'($urandom) : NO_KEYS;
      sample_ms += pick_step();
      send_sample(pack_sample(one_hot, one_hot | extra));
      if ($urandom_range(0, 3) == 0) begin
         sample_ms += $urandom_range(0, active_cfg.debounce_ms + 1);
         send_sample(pack_sample(one_hot, one_hot));
      end
      holds = $urandom_range(1, 12);
      repeat (holds) begin
         sample_ms += hold_step();
         extra = ($urandom_range(0, 4) == 0) ? 4'($urandom) : NO_KEYS;
         if ($urandom_range(0, 9) == 0)
            send_sample(pack_sample(NO_KEYS, ~one_hot & 4'($urandom_range(1, 15))));
         else
            send_sample(pack_sample(NO_KEYS, one_hot | extra));
      end
      if ($urandom_range(0, 1) == 1) begin
         sample_ms += pick_step();
         send_sample(pack_sample(NO_KEYS, NO_KEYS));
      end
   endtask

   // Any combination of edges and levels; most keep the clock moving forward,
   // the rest carry an arbitrary time.
   task automatic noise_sample();
      req_type s;
      s = req_type'(40'({$urandom, $urandom}));
      if ($urandom_range(0, 4) != 0) begin
         sample_ms += pick_step();
         s.now_ms = sample_ms;
      end
      send_sample(s);
   endtask

   // Hand-picked samples at reset settings (debounce 130, initial delay 700,
   // interval 95, two vertical steps). Times are chosen to sit on the edges
   // of the bounce window and of the repeat due time.
   task automatic directed_samples();
      sample_at(32'd0, NO_KEYS, NO_KEYS);
      sample_at(32'd10, KEY_LEFT, KEY_LEFT);
      sample_at(32'd50, KEY_LEFT, KEY_LEFT);                  // bounce inside window
      sample_at(32'd139, KEY_LEFT, KEY_LEFT);                 // last ms of the window
      sample_at(32'd140, KEY_LEFT, KEY_LEFT);                 // window just closed
      sample_at(32'd839, NO_KEYS, KEY_LEFT);                  // one ms before due
      sample_at(32'd840, NO_KEYS, KEY_LEFT);                  // first repeat
      sample_at(32'd935, NO_KEYS, KEY_LEFT | KEY_UP);         // repeat with another key held
      sample_at(32'd1200, KEY_RIGHT | KEY_UP | KEY_DOWN, ALL_KEYS); // priority picks right
      sample_at(32'd1900, NO_KEYS, KEY_UP);                   // armed key let go, disarm
      sample_at(32'd2000, NO_KEYS, KEY_RIGHT);                // nothing armed any more
      sample_at(32'd2100, KEY_UP, KEY_UP);
      sample_at(32'd2800, NO_KEYS, KEY_UP);                   // vertical repeat
      sample_at(32'd2800, NO_KEYS, KEY_UP);
      sample_at(32'd2900, NO_KEYS, NO_KEYS);                  // full release
      sample_at(32'd2950, KEY_DOWN, KEY_DOWN);
      // Around the wrap of the millisecond clock: the due time wraps to a
      // small value, so the plain compare fires the repeat early.
      sample_at(32'hFFFF_FFC0, KEY_DOWN, KEY_DOWN);
      sample_at(32'hFFFF_FFD0, NO_KEYS, KEY_DOWN);
      sample_at(32'h0000_0010, KEY_DOWN, KEY_DOWN);           // bounce across the wrap
      sample_at(32'h0000_0020, NO_KEYS, KEY_DOWN);
      sample_at(32'h0000_0030, NO_KEYS, KEY_DOWN);
      sample_at(32'hFFFF_FFFF, ALL_KEYS, ALL_KEYS);
      sample_at(32'hFFFF_FFFF, KEY_LEFT, NO_KEYS);
      sample_at(32'h0000_0100, NO_KEYS, ALL_KEYS);
   endtask

   // The result side stalls at random while gaps are enabled, and holds off
   // for a long stretch on request so that the unit backs up.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_request = 1'b0;
         end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            rsp_stall <= 1'b1;
            repeat (idle_cycles()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_move(rsp_data);
   end

   initial begin
      #3_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      cfg_type     plan[PHASE_COUNT];
      int unsigned phase_end;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      sample_ms        = '0;
      gaps_on          = 1'b0;
      hold_off_request = 1'b0;
      items_sent       = 0;
      settings_applied = 0;
      active_cfg = '{debounce_ms: DEBOUNCE_RESET, repeat_initial_ms: REPEAT_INITIAL_RESET,
                     repeat_interval_ms: REPEAT_INTERVAL_RESET,
                     vertical_repeat_steps: VERTICAL_STEPS_RESET};

      // Zero everywhere (a step count of zero acts as one), all ones, a fast
      // small setting, the reset values, and two random settings.
      plan[0] = '{debounce_ms: 16'd0, repeat_initial_ms: 16'd0,
                  repeat_interval_ms: 16'd0, vertical_repeat_steps: 2'd0};
      plan[1] = '{debounce_ms: 16'hFFFF, repeat_initial_ms: 16'hFFFF,
                  repeat_interval_ms: 16'hFFFF, vertical_repeat_steps: 2'd3};
      plan[2] = '{debounce_ms: 16'd20, repeat_initial_ms: 16'd60,
                  repeat_interval_ms: 16'd15, vertical_repeat_steps: 2'd1};
      plan[3] = active_cfg;
      for (int p = 4; p < PHASE_COUNT; p++) begin
         plan[p].debounce_ms           = 16'($urandom_range(0, 300));
         plan[p].repeat_initial_ms     = 16'($urandom_range(0, 1000));
         plan[p].repeat_interval_ms    = 16'($urandom_range(0, 200));
         plan[p].vertical_repeat_steps = 2'($urandom_range(0, 3));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_samples();
      drain_moves();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_settings(plan[p]);
         // The fast setting starts with the receiver held off and the sender
         // pushing back to back, so the unit fills and stalls its input.
         gaps_on = (p != 2);
         if (p == 2) hold_off_request = 1'b1;
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 39) == 0)
               sample_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * active_cfg.repeat_initial_ms + 200);
            if ($urandom_range(0, 9) < 7) keystroke();
            else noise_sample();
            if ($urandom_range(0, 29) == 0) drain_moves();
         end
         drain_moves();
      end

      $display("covered %0d samples over %0d register settings plus reset values",
               items_sent, settings_applied);
      $display("predicted %0d edge moves, %0d repeats, %0d bounces, %0d disarms by other keys",
               tracker.edge_moves, tracker.repeat_moves, tracker.bounces, tracker.disarms);
      if (tracker.failures == 0 && tracker.expected_moves.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
